// File: sv/pfe_pkg.sv
// pfe_pkg: shared types, codes and grid helpers for the playfair digraph encryptor
// used by every module of the block; depends on nothing
`default_nettype none
package pfe_pkg;

	localparam int GRID_SIDE  = 5;
	localparam int GRID_CELLS = 25;
	localparam int ALPHA      = 26;
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = $clog2(QDEPTH);

	// input function codes
	localparam logic [2:0] F_CLEAR  = 3'd0;
	localparam logic [2:0] F_KEY    = 3'd1;
	localparam logic [2:0] F_FINISH = 3'd2;
	localparam logic [2:0] F_TEXT   = 3'd3;
	localparam logic [2:0] F_SPACE  = 3'd4;

	// result status codes
	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_NOT_IN_GRID = 2'd1;
	localparam logic [1:0] ST_NO_KEY      = 2'd2;

	// register indexes on the apb port
	localparam logic [1:0] REG_OMITTED   = 2'd0;
	localparam logic [1:0] REG_FILLER    = 2'd1;
	localparam logic [1:0] REG_ALTERNATE = 2'd2;

	typedef struct packed {
		logic [4:0] first;
		logic [4:0] second;
		logic       last;
		logic [1:0] status;
	} pair_req_t;

	typedef struct packed {
		logic       we;
		logic [4:0] pos;
		logic [4:0] letter;
	} mem_wr_t;

	typedef struct packed {
		logic [4:0] omitted;
		logic [4:0] filler;
		logic [4:0] alternate;
	} cfg_t;

	typedef struct packed {
		logic [2:0] row;
		logic [2:0] col;
	} rc_t;

	// split a cell index 0..24 into row and column
	function automatic rc_t cell_rc(input logic [4:0] p);
		rc_t r;
		if (p >= 5'd20) begin
			r.row = 3'd4;
		end else if (p >= 5'd15) begin
			r.row = 3'd3;
		end else if (p >= 5'd10) begin
			r.row = 3'd2;
		end else if (p >= 5'd5) begin
			r.row = 3'd1;
		end else begin
			r.row = 3'd0;
		end
		r.col = 3'(p - 5'(r.row * GRID_SIDE));
		return r;
	endfunction

	function automatic logic [2:0] wrap_inc(input logic [2:0] v);
		return (v == 3'(GRID_SIDE - 1)) ? 3'd0 : 3'(v + 3'd1);
	endfunction

	function automatic logic [4:0] cell_idx(input logic [2:0] row, input logic [2:0] col);
		return 5'(row * GRID_SIDE + col);
	endfunction

endpackage
`default_nettype wire

// File: sv/pfe_channels.sv
// pfe_item_if / pfe_pair_if: valid-ready channels of the encryptor
// input items and enciphered pairs; no dependencies
`default_nettype none
interface pfe_item_if;
	logic       valid;
	logic       ready;
	logic [2:0] func;
	logic [4:0] letter;
	logic       end_of_message;

	modport source(output valid, output func, output letter, output end_of_message,
		input ready);
	modport sink(input valid, input func, input letter, input end_of_message,
		output ready);
endinterface

interface pfe_pair_if;
	logic       valid;
	logic       ready;
	logic [4:0] cipher_first;
	logic [4:0] cipher_second;
	logic       last_of_message;
	logic [1:0] status;

	modport source(output valid, output cipher_first, output cipher_second,
		output last_of_message, output status, input ready);
	modport sink(input valid, input cipher_first, input cipher_second,
		input last_of_message, input status, output ready);
endinterface
`default_nettype wire

// File: sv/pfe_front.sv
// pfe_front: accepts items, keeps key marks and the held letter, builds pair requests
// depends on pfe_pkg and pfe_item_if; writes the grid memories of pfe_back
`default_nettype none
module pfe_front (
	input  wire                 clk,
	input  wire                 arst_n,
	pfe_item_if.sink            item,
	input  pfe_pkg::cfg_t       cfg,
	input  wire                 drained,
	input  wire                 q_full,
	output logic                q_push,
	output pfe_pkg::pair_req_t  q_din,
	output pfe_pkg::mem_wr_t    mem_wr
);
	import pfe_pkg::*;

	localparam logic [1:0] FE_RUN    = 2'd0;
	localparam logic [1:0] FE_SECOND = 2'd1;
	localparam logic [1:0] FE_DRAIN  = 2'd2;
	localparam logic [1:0] FE_WALK   = 2'd3;

	logic [1:0]       state_q;
	logic [ALPHA-1:0] used_q;
	logic [4:0]       filled_q;
	logic             key_ready_q;
	logic [4:0]       held_q;
	logic             held_valid_q;
	pair_req_t        second_q;
	logic [2:0]       kfunc_q;
	logic [4:0]       kletter_q;
	logic [4:0]       walk_q;

	logic       acc;
	logic       sec_go;
	pair_req_t  sec_req;
	logic [4:0] held_d;
	logic       held_valid_d;
	logic [4:0] place_l;
	logic       place_en;

	function automatic logic in_grid(input logic [4:0] l);
		return (l < 5'(ALPHA)) ? used_q[l] : 1'b0;
	endfunction

	function automatic logic [4:0] pad_for(input logic [4:0] l);
		return (l == cfg.filler) ? cfg.alternate : cfg.filler;
	endfunction

	function automatic pair_req_t mk(input logic [4:0] a, input logic [4:0] b,
		input logic last);
		pair_req_t r;
		r.last = last;
		if (in_grid(a) && in_grid(b)) begin
			r.first  = a;
			r.second = b;
			r.status = ST_OK;
		end else begin
			r.first  = '0;
			r.second = '0;
			r.status = ST_NOT_IN_GRID;
		end
		return r;
	endfunction

	function automatic pair_req_t err(input logic [1:0] code, input logic last);
		pair_req_t r;
		r.first  = '0;
		r.second = '0;
		r.last   = last;
		r.status = code;
		return r;
	endfunction

	assign item.ready = (state_q == FE_RUN) && !q_full;
	assign acc        = item.valid && item.ready;

	// classify a text letter or space into up to two requests
	always_comb begin
		q_push       = 1'b0;
		q_din        = '0;
		sec_go       = 1'b0;
		sec_req      = '0;
		held_d       = held_q;
		held_valid_d = held_valid_q;
		if (state_q == FE_SECOND) begin
			q_push = !q_full;
			q_din  = second_q;
		end else if (acc) begin
			case (item.func)
				F_TEXT: begin
					q_push = 1'b1;
					if (!key_ready_q) begin
						q_din = err(ST_NO_KEY, item.end_of_message);
					end else if (!in_grid(item.letter)) begin
						if (item.end_of_message && held_valid_q) begin
							q_din        = err(ST_NOT_IN_GRID, 1'b0);
							sec_go       = 1'b1;
							sec_req      = mk(held_q, pad_for(held_q), 1'b1);
							held_valid_d = 1'b0;
						end else begin
							q_din = err(ST_NOT_IN_GRID, item.end_of_message);
						end
					end else if (!held_valid_q) begin
						if (item.end_of_message) begin
							q_din = mk(item.letter, pad_for(item.letter), 1'b1);
						end else begin
							q_push       = 1'b0;
							held_d       = item.letter;
							held_valid_d = 1'b1;
						end
					end else if (item.letter == held_q) begin
						q_din = mk(held_q, pad_for(held_q), 1'b0);
						if (item.end_of_message) begin
							sec_go       = 1'b1;
							sec_req      = mk(item.letter, pad_for(item.letter), 1'b1);
							held_valid_d = 1'b0;
						end
					end else begin
						q_din        = mk(held_q, item.letter, item.end_of_message);
						held_valid_d = 1'b0;
					end
				end
				F_SPACE: begin
					if (item.end_of_message && held_valid_q) begin
						q_push       = 1'b1;
						q_din        = mk(held_q, pad_for(held_q), 1'b1);
						held_valid_d = 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// grid placement, from a key letter or the finishing walk
	assign place_l  = (state_q == FE_WALK) ? walk_q : kletter_q;
	assign place_en = (state_q == FE_WALK) ||
		((state_q == FE_DRAIN) && drained && (kfunc_q == F_KEY) && !key_ready_q);

	always_comb begin
		mem_wr.pos    = filled_q;
		mem_wr.letter = place_l;
		mem_wr.we     = place_en && (place_l < 5'(ALPHA)) && (place_l != cfg.omitted) &&
			!used_q[place_l] && (filled_q < 5'(GRID_CELLS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= FE_RUN;
			used_q       <= '0;
			filled_q     <= '0;
			key_ready_q  <= 1'b0;
			held_q       <= '0;
			held_valid_q <= 1'b0;
			walk_q       <= '0;
		end else begin
			if (mem_wr.we) begin
				used_q[place_l] <= 1'b1;
				filled_q        <= 5'(filled_q + 5'd1);
			end
			unique case (state_q)
				FE_RUN: begin
					if (acc) begin
						case (item.func)
							F_CLEAR: begin
								used_q       <= '0;
								filled_q     <= '0;
								key_ready_q  <= 1'b0;
								held_q       <= '0;
								held_valid_q <= 1'b0;
							end
							F_KEY, F_FINISH: begin
								state_q <= FE_DRAIN;
							end
							default: begin
								held_q       <= held_d;
								held_valid_q <= held_valid_d;
								if (sec_go) begin
									state_q <= FE_SECOND;
								end
							end
						endcase
					end
				end
				FE_SECOND: begin
					if (!q_full) begin
						state_q <= FE_RUN;
					end
				end
				FE_DRAIN: begin
					// grid memories change only once the back end holds no request
					if (drained) begin
						if (kfunc_q == F_FINISH && !key_ready_q) begin
							state_q <= FE_WALK;
							walk_q  <= '0;
						end else begin
							state_q <= FE_RUN;
						end
					end
				end
				FE_WALK: begin
					if (walk_q == 5'(ALPHA - 1)) begin
						key_ready_q <= 1'b1;
						state_q     <= FE_RUN;
					end else begin
						walk_q <= 5'(walk_q + 5'd1);
					end
				end
				default: state_q <= FE_RUN;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			kfunc_q   <= item.func;
			kletter_q <= item.letter;
		end
		if (sec_go && state_q == FE_RUN) begin
			second_q <= sec_req;
		end
	end

endmodule
`default_nettype wire

// File: sv/pfe_queue.sv
// pfe_queue: short request queue between front and back end
// depends on pfe_pkg for the request type and depth
`default_nettype none
module pfe_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  pfe_pkg::pair_req_t  din,
	input  wire                 pop,
	output pfe_pkg::pair_req_t  dout,
	output logic                full,
	output logic                empty
);
	import pfe_pkg::*;

	pair_req_t         slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   count_q;

	assign full  = (count_q == (QPTR_W + 1)'(QDEPTH));
	assign empty = (count_q == '0);
	assign dout  = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= QPTR_W'(wr_q + 1'b1);
			end
			if (pop) begin
				rd_q <= QPTR_W'(rd_q + 1'b1);
			end
			if (push && !pop) begin
				count_q <= (QPTR_W + 1)'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= (QPTR_W + 1)'(count_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= din;
		end
	end

endmodule
`default_nettype wire

// File: sv/pfe_back.sv
// pfe_back: grid and letter position memories, pair lookup and output register
// depends on pfe_pkg and pfe_pair_if; fed by pfe_queue, written by pfe_front
`default_nettype none
module pfe_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 q_empty,
	input  pfe_pkg::pair_req_t  q_head,
	output logic                q_pop,
	input  pfe_pkg::mem_wr_t    mem_wr,
	output logic                idle,
	pfe_pair_if.source          pair
);
	import pfe_pkg::*;

	localparam logic [1:0] BK_IDLE  = 2'd0;
	localparam logic [1:0] BK_PLACE = 2'd1;
	localparam logic [1:0] BK_OUT   = 2'd2;

	logic [4:0] grid_mem  [GRID_CELLS];
	logic [4:0] place_mem [ALPHA];

	logic [1:0] state_q;
	pair_req_t  req_q;
	logic [4:0] pa_q;
	logic [4:0] pb_q;
	logic [4:0] ga_q;
	logic [4:0] gb_q;

	rc_t        rc_a;
	rc_t        rc_b;
	logic [4:0] xa;
	logic [4:0] xb;

	assign idle  = (state_q == BK_IDLE);
	assign q_pop = !q_empty && ((state_q == BK_IDLE) || (state_q == BK_OUT && pair.ready));

	// row, column or rectangle rule on the looked-up positions
	always_comb begin
		rc_a = cell_rc(pa_q);
		rc_b = cell_rc(pb_q);
		if (rc_a.row == rc_b.row) begin
			xa = cell_idx(rc_a.row, wrap_inc(rc_a.col));
			xb = cell_idx(rc_b.row, wrap_inc(rc_b.col));
		end else if (rc_a.col == rc_b.col) begin
			xa = cell_idx(wrap_inc(rc_a.row), rc_a.col);
			xb = cell_idx(wrap_inc(rc_b.row), rc_b.col);
		end else begin
			xa = cell_idx(rc_a.row, rc_b.col);
			xb = cell_idx(rc_b.row, rc_a.col);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_wr.we) begin
			grid_mem[mem_wr.pos]     <= mem_wr.letter;
			place_mem[mem_wr.letter] <= mem_wr.pos;
		end
		if (q_pop) begin
			req_q <= q_head;
			pa_q  <= place_mem[q_head.first];
			pb_q  <= place_mem[q_head.second];
		end
		if (state_q == BK_PLACE) begin
			ga_q <= grid_mem[xa];
			gb_q <= grid_mem[xb];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			unique case (state_q)
				BK_IDLE: begin
					if (q_pop) begin
						state_q <= BK_PLACE;
					end
				end
				BK_PLACE: state_q <= BK_OUT;
				BK_OUT: begin
					if (pair.ready) begin
						state_q <= q_pop ? BK_PLACE : BK_IDLE;
					end
				end
				default: state_q <= BK_IDLE;
			endcase
		end
	end

	assign pair.valid           = (state_q == BK_OUT);
	assign pair.cipher_first    = (req_q.status == ST_OK) ? ga_q : 5'd0;
	assign pair.cipher_second   = (req_q.status == ST_OK) ? gb_q : 5'd0;
	assign pair.last_of_message = req_q.last;
	assign pair.status          = req_q.status;

endmodule
`default_nettype wire

// File: sv/playfair_digraph_encryptor.sv
// playfair_digraph_encryptor: top level with the register port and the three parts
// depends on pfe_pkg, pfe_channels, pfe_front, pfe_queue and pfe_back
//
// usage:
//   in_ch carries items (func, letter, end_of_message) by valid/ready; out_ch carries
//   enciphered pairs with last_of_message and status. registers on the apb port:
//   0x0 omitted_letter, 0x4 filler_letter, 0x8 alternate_filler (5 bits each).
//   a text letter or space is classified combinationally and its request(s) go to a
//   four-entry queue; the back end takes each request through a letter position read
//   and a grid read, each registered in turn before the pair is presented; the next
//   request is popped as a pair is taken, then waits for its own grid read.
//   an item that makes two pairs holds the input until its second request is queued.
//   key letters and finish key wait until the queue and back end are empty, since
//   they write the grid memories; finish key then walks the 26 letter marks, one
//   per cycle, before the next item is taken.
//   while out_ch is stalled the front keeps taking text until the queue fills.
//   reset restores the register defaults, empties the key and drops any held letter;
//   the grid memories are not cleared; only an error request reads unplaced cells.
`default_nettype none
module playfair_digraph_encryptor (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [3:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	pfe_item_if.sink    in_ch,
	pfe_pair_if.source  out_ch
);
	import pfe_pkg::*;

	cfg_t      cfg_q;
	logic      wr_en;
	logic      drained;
	logic      q_push;
	logic      q_pop;
	logic      q_full;
	logic      q_empty;
	logic      back_idle;
	pair_req_t q_din;
	pair_req_t q_head;
	mem_wr_t   mem_wr;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.omitted   <= 5'd10;
			cfg_q.filler    <= 5'd22;
			cfg_q.alternate <= 5'd25;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_OMITTED:   cfg_q.omitted   <= pwdata[4:0];
				REG_FILLER:    cfg_q.filler    <= pwdata[4:0];
				REG_ALTERNATE: cfg_q.alternate <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_OMITTED:   prdata = {27'd0, cfg_q.omitted};
			REG_FILLER:    prdata = {27'd0, cfg_q.filler};
			REG_ALTERNATE: prdata = {27'd0, cfg_q.alternate};
			default:       prdata = '0;
		endcase
	end

	assign drained = q_empty && back_idle;

	pfe_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (in_ch),
		.cfg     (cfg_q),
		.drained (drained),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_din   (q_din),
		.mem_wr  (mem_wr)
	);

	pfe_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.pop    (q_pop),
		.dout   (q_head),
		.full   (q_full),
		.empty  (q_empty)
	);

	pfe_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.mem_wr  (mem_wr),
		.idle    (back_idle),
		.pair    (out_ch)
	);

	// grid memories must not change under a request still in flight
	a_write_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr.we |-> drained)
		else $error("grid memory written while requests are pending");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (!q_full || q_pop))
		else $error("request pushed into a full queue");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.status != ST_OK) |->
		(out_ch.cipher_first == 5'd0 && out_ch.cipher_second == 5'd0))
		else $error("error result carries cipher letters");

endmodule
`default_nettype wire
